@@ rtl/msm_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the multi-stack pop-min block
// no dependencies; imported by the top level and the testbench

package msm_pkg;

  localparam int NUM_STACKS  = 4;
  localparam int STACK_DEPTH = 16;

  localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DATA_W = 32;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped_value;
    logic [1:0]         popped_stack;
  } rsp_t;

endpackage

@@ rtl/msm_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/multi_stack_min_top_pop.sv @@
`timescale 1ns / 1ps
// top level: several bounded stacks with push and pop-smallest-top
// depends on msm_pkg and msm_ram

// Takes one request when start is high and busy is low. A push writes the
// value on top of the chosen stack; if that stack is full, or the stack number
// is not below NUM_STACKS, nothing is stored and status reports full. A pop
// walks the stacks one after another, reading each non-empty top from the
// shared stack ram and comparing it with the best so far in one signed
// comparator; the smallest top is removed, ties going to the lower stack.
// With every stack empty, status reports empty and nothing changes. A push
// goes through the push state alone; a pop spends a ram read state and a
// compare state on each stack in turn, then a pop state. Each result is
// shown on result for a single cycle with done high and must be taken then:
// there is no way to hold it off. A new request may be taken in that same
// cycle. The stack ram needs no clearing after reset; only the counts are
// cleared.

module multi_stack_min_top_pop
  import msm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t result
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_PUSH    = 5'b00010,
    S_READ    = 5'b00100,
    S_COMPARE = 5'b01000,
    S_POP     = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] count [NUM_STACKS];

  // request held while the sequencer works
  logic [IDX_W-1:0]  idx;
  logic              bad_sel;
  logic [DATA_W-1:0] value;

  // scan state for pop
  logic              top_valid;
  logic [CNT_W-1:0]  cur_count;
  logic              found;
  logic [IDX_W-1:0]  best;
  logic [DATA_W-1:0] best_val;
  logic [CNT_W-1:0]  best_count;

  // ram hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  sel_count;
  logic [ADDR_W-1:0] base;
  logic              push_ok;
  logic              better;
  logic              last_stack;

  // the only read of the count array goes through idx
  assign sel_count = count[idx];
  assign base      = ADDR_W'(ADDR_W'(idx) * ADDR_W'(STACK_DEPTH));
  assign push_ok   = !bad_sel && (32'(sel_count) < STACK_DEPTH);

  assign ram_we    = (state == S_PUSH) && push_ok;
  assign ram_waddr = ADDR_W'(base + ADDR_W'(sel_count));
  // top of stack idx; garbage address when empty, result is ignored then
  assign ram_raddr = ADDR_W'(base + ADDR_W'(sel_count - CNT_W'(1)));

  // shared signed comparator, strict so that ties keep the lower stack
  assign better     = top_valid && (!found || ($signed(ram_rdata) < $signed(best_val)));
  assign last_stack = (idx == IDX_W'(NUM_STACKS - 1));

  assign busy = (state != S_IDLE);

  msm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WORDS),
    .AW   (ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            found <= 1'b0;
            if (req.opcode == OP_PUSH) begin
              state <= S_PUSH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            count[idx] <= CNT_W'(sel_count + CNT_W'(1));
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_READ: begin
          state <= S_COMPARE;
        end
        S_COMPARE: begin
          if (better) begin
            found <= 1'b1;
          end
          if (last_stack) begin
            state <= S_POP;
          end else begin
            state <= S_READ;
          end
        end
        S_POP: begin
          if (found) begin
            count[best] <= CNT_W'(best_count - CNT_W'(1));
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          value   <= req.push_value;
          bad_sel <= (32'(req.stack_sel) >= NUM_STACKS);
          if (req.opcode == OP_PUSH) begin
            idx <= IDX_W'(req.stack_sel);
          end else begin
            idx <= '0;
          end
        end
      end
      S_PUSH: begin
        result.status       <= push_ok ? ST_OK : ST_FULL;
        result.popped_value <= '0;
        result.popped_stack <= '0;
      end
      S_READ: begin
        top_valid <= (sel_count != '0);
        cur_count <= sel_count;
      end
      S_COMPARE: begin
        if (better) begin
          best       <= idx;
          best_val   <= ram_rdata;
          best_count <= cur_count;
        end
        if (!last_stack) begin
          idx <= IDX_W'(idx + IDX_W'(1));
        end
      end
      S_POP: begin
        if (found) begin
          result.status       <= ST_OK;
          result.popped_value <= best_val;
          result.popped_stack <= 2'(best);
        end else begin
          result.status       <= ST_EMPTY;
          result.popped_value <= '0;
          result.popped_stack <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ test/tb_multi_stack_min_top_pop.sv @@
`timescale 1ns / 1ps
// testbench for multi_stack_min_top_pop: push / pop-smallest-top checking
// depends on msm_pkg and the multi_stack_min_top_pop rtl only

module tb_multi_stack_min_top_pop;
  import msm_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  // a pop walks every stack, so the quiet tail grows with the number of stacks
  localparam int DRAIN_CYCLES = 4 * NUM_STACKS + 8;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t req_bus;
  logic busy;
  logic done;
  rsp_t result;

  // mirror of the stacks plus the queue of responses still owed by the block
  class stack_tracker;
    logic signed [DATA_W-1:0] contents [NUM_STACKS][STACK_DEPTH];
    int unsigned depth_used [NUM_STACKS];
    rsp_t awaited [$];
    int errors;
    int n_push;
    int n_full;
    int n_pop;
    int n_empty;
    int n_checked;

    function new();
      foreach (depth_used[s]) depth_used[s] = 0;
      errors = 0;
      n_push = 0;
      n_full = 0;
      n_pop = 0;
      n_empty = 0;
      n_checked = 0;
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    // applies one request to the mirror and returns the response it must give
    function rsp_t predict_response(req_t r);
      rsp_t o;
      int best;
      int s;
      logic signed [DATA_W-1:0] best_val;
      o.status = ST_OK;
      o.popped_value = '0;
      o.popped_stack = '0;
      best = -1;
      best_val = '0;
      if (r.opcode == OP_PUSH) begin
        if (r.stack_sel >= NUM_STACKS || depth_used[r.stack_sel] >= STACK_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          contents[r.stack_sel][depth_used[r.stack_sel]] = r.push_value;
          depth_used[r.stack_sel]++;
        end
      end else begin
        // strict less-than keeps the lower stack on equal tops
        for (s = 0; s < NUM_STACKS; s++) begin
          if (depth_used[s] != 0) begin
            if (best < 0 || contents[s][depth_used[s] - 1] < best_val) begin
              best = s;
              best_val = contents[s][depth_used[s] - 1];
            end
          end
        end
        if (best < 0) begin
          o.status = ST_EMPTY;
        end else begin
          depth_used[best]--;
          o.popped_value = best_val;
          o.popped_stack = 2'(best);
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      want = predict_response(r);
      if (r.opcode == OP_PUSH) begin
        n_push++;
        if (want.status == ST_FULL) n_full++;
      end else begin
        n_pop++;
        if (want.status == ST_EMPTY) n_empty++;
      end
      awaited = {awaited, want};
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: status=%0d value=%0d stack=%0d",
                         got.status, got.popped_value, got.popped_stack));
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.popped_value !== want.popped_value)
        report($sformatf("popped_value %0d, expected %0d",
                         got.popped_value, want.popped_value));
      if (got.popped_stack !== want.popped_stack)
        report($sformatf("popped_stack %0d, expected %0d",
                         got.popped_stack, want.popped_stack));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  stack_tracker tracker;

  multi_stack_min_top_pop dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req_bus),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: both sides sampled on the same edge the block uses
  // note the request first so a response on the same edge still finds its entry
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_request(req_bus);
      if (done) tracker.check_result(result);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // one request: optional idle gap, then hold start until the block takes it
  // start is only lowered when there is a gap, so back-to-back stays high
  task automatic send_request(input logic op, input logic [1:0] sel,
                              input logic signed [DATA_W-1:0] val, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_bus <= '{op, sel, val};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 14);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  // mix of extremes, a narrow band that produces equal tops, and full range
  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int round_len;
    int push_pct;
    int focus;
    int focus_pct;
    int gap_mode;
    int i;
    logic op;
    logic [1:0] sel;

    tracker = new();
    start = 1'b0;
    req_bus = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: pop on empty stacks
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    // extremes, one per stack, then drained smallest first
    send_request(OP_PUSH, 2'd0, 32'sh8000_0000, 0);
    send_request(OP_PUSH, 2'd1, 32'sh7fff_ffff, 0);
    send_request(OP_PUSH, 2'd2, 32'sd0, 2);
    send_request(OP_PUSH, 2'd3, -32'sd1, 0);
    send_request(OP_POP, 2'd3, 32'sh7fff_ffff, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd1, 32'sd0, 3);
    send_request(OP_POP, 2'd2, 32'sh8000_0000, 0);
    // everything drained again
    send_request(OP_POP, 2'd3, 32'sd0, 0);
    // equal tops on three stacks: lowest stack number goes first
    send_request(OP_PUSH, 2'd1, 32'sd7, 0);
    send_request(OP_PUSH, 2'd3, 32'sd7, 0);
    send_request(OP_PUSH, 2'd2, 32'sd7, 1);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    // only the top of a stack competes, even when a lower entry is smaller
    send_request(OP_PUSH, 2'd0, 32'sh5555_5555, 0);
    send_request(OP_PUSH, 2'd0, 32'shaaaa_aaaa, 0);
    send_request(OP_PUSH, 2'd1, 32'sh8000_0000, 0);
    send_request(OP_PUSH, 2'd1, 32'sh1234_5678, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);
    send_request(OP_POP, 2'd0, 32'sd0, 0);

    // random rounds: fill-heavy rounds overflow a favored stack, drain-heavy
    // rounds empty everything, mixed rounds keep several stacks competing
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      round_len = $urandom_range(10, 60);
      if (round_len > RANDOM_ITEMS - sent) round_len = RANDOM_ITEMS - sent;
      case ($urandom_range(0, 3))
        0: push_pct = 90;
        1: push_pct = 15;
        2: push_pct = 50;
        default: push_pct = 70;
      endcase
      focus = $urandom_range(0, NUM_STACKS - 1);
      focus_pct = $urandom_range(0, 100);
      gap_mode = $urandom_range(0, 2);
      for (i = 0; i < round_len; i++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        sel = ($urandom_range(0, 99) < focus_pct) ? 2'(focus) : 2'($urandom_range(0, 3));
        // ignored fields of a pop still get random content
        send_request(op, sel, draw_value(), draw_gap(gap_mode));
      end
      sent += round_len;
    end
    start <= 1'b0;

    // wait for every owed response, then a quiet tail
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d pushes (%0d refused on a full stack), %0d pops (%0d on empty)",
             tracker.n_push, tracker.n_full, tracker.n_pop, tracker.n_empty);
    $display("%0d responses compared, %0d mismatches", tracker.n_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/msm_pkg.sv
rtl/msm_ram.sv
rtl/multi_stack_min_top_pop.sv
test/tb_multi_stack_min_top_pop.sv
